### rtl/rmq_pkg.sv
// shared constants for the rotation matrix to quaternion block
package rmq_pkg;

   localparam int FRAC_BITS_DEF = 14;
   localparam int DATA_W = 16;
   localparam int DIFF_W = DATA_W + 1;
   localparam int QBITS = DATA_W - 1;

   localparam logic [1:0] SEL_W = 2'd0;
   localparam logic [1:0] SEL_X = 2'd1;
   localparam logic [1:0] SEL_Y = 2'd2;
   localparam logic [1:0] SEL_Z = 2'd3;

   localparam logic signed [DATA_W-1:0] SAT_MAX = 16'sh7FFF;
   localparam logic signed [DATA_W-1:0] SAT_MIN = 16'sh8000;

endpackage

### rtl/rmq_if.sv
// valid/ready channel interfaces for matrix beats and quaternion beats
interface rmq_req_if;
   logic valid;
   logic ready;
   logic signed [rmq_pkg::DATA_W-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
   modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, input ready);
   modport sink (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, output ready);
endinterface

interface rmq_rsp_if;
   logic valid;
   logic ready;
   logic signed [rmq_pkg::DATA_W-1:0] quat_w, quat_x, quat_y, quat_z;
   logic root_fault;
   modport source (output valid, quat_w, quat_x, quat_y, quat_z, root_fault, input ready);
   modport sink (input valid, quat_w, quat_x, quat_y, quat_z, root_fault, output ready);
endinterface

### rtl/rotation_matrix_to_quaternion.sv
// rotation matrix to quaternion converter, pipelined square root and dividers
// register order: front stage, square root stages, overflow stage, divider stages, output register;
// SQ_W = ceil((max(FRAC_BITS,17)+1+FRAC_BITS)/2) root bits; one root bit and one quotient bit per stage
// throughput: one beat per cycle; the whole pipe holds while the output beat waits
// reset clears every pipeline register, valid bits included
module rotation_matrix_to_quaternion #(
   parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
   input logic clock,
   input logic reset,
   rmq_req_if.sink req_port,
   rmq_rsp_if.source rsp_port
);

   localparam int DW = rmq_pkg::DATA_W;
   localparam int FW = rmq_pkg::DIFF_W;
   localparam int QB = rmq_pkg::QBITS;
   localparam int RAD_W = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
   localparam int NW = RAD_W - 1 + FRAC_BITS;
   localparam int SQ_W = (NW + 1) / 2;
   localparam int NN = 2 * SQ_W;
   localparam int DV_W = FW + FRAC_BITS;
   localparam int CW = ((DV_W > SQ_W + QB + 1) ? DV_W : SQ_W + QB + 1) + 1;

   typedef struct packed {
      logic valid;
      logic fault;
      logic [1:0] sel;
      logic [2:0] neg;
      logic [2:0][FW-1:0] mag;
      logic [NN-1:0] n;
      logic [SQ_W+1:0] rem;
      logic [SQ_W-1:0] root;
   } sq_type;

   typedef struct packed {
      logic valid;
      logic fault;
      logic [1:0] sel;
      logic [2:0] neg;
      logic [2:0] ovf;
      logic [2:0][CW-1:0] rem;
      logic [2:0][QB-1:0] q;
      logic [CW-1:0] ds;
      logic signed [DW-1:0] main;
   } dv_type;

   typedef struct packed {
      logic valid;
      logic fault;
      logic signed [3:0][DW-1:0] quat;
   } out_type;

   sq_type sq_ff [0:SQ_W];
   sq_type sq_in [0:SQ_W];
   dv_type dv_ff [0:QB];
   dv_type dv_in [0:QB];
   out_type out_ff, out_in;
   logic en;

   assign en = !out_ff.valid || rsp_port.ready;
   assign req_port.ready = en;

   // front stage: branch choice, radicand and off-diagonal terms
   always_comb begin
      logic signed [RAD_W-1:0] m00, m11, m22, one, tr, rad;
      logic signed [FW-1:0] d [0:2];
      logic signed [FW-1:0] a01, a02, a10, a12, a20, a21;
      m00 = RAD_W'(req_port.r00);
      m11 = RAD_W'(req_port.r11);
      m22 = RAD_W'(req_port.r22);
      a01 = FW'(req_port.r01);
      a02 = FW'(req_port.r02);
      a10 = FW'(req_port.r10);
      a12 = FW'(req_port.r12);
      a20 = FW'(req_port.r20);
      a21 = FW'(req_port.r21);
      one = RAD_W'(1) <<< FRAC_BITS;
      tr = m00 + m11 + m22;
      sq_in[0] = '0;
      if (tr > 0) begin
         sq_in[0].sel = rmq_pkg::SEL_W;
         rad = tr + one;
         d[0] = a21 - a12;
         d[1] = a02 - a20;
         d[2] = a10 - a01;
      end else if ((m11 > m00 && m22 > m11) || (!(m11 > m00) && m22 > m00)) begin
         sq_in[0].sel = rmq_pkg::SEL_Z;
         rad = m22 - m00 - m11 + one;
         d[0] = a02 + a20;
         d[1] = a12 + a21;
         d[2] = a10 - a01;
      end else if (m11 > m00) begin
         sq_in[0].sel = rmq_pkg::SEL_Y;
         rad = m11 - m22 - m00 + one;
         d[0] = a01 + a10;
         d[1] = a21 + a12;
         d[2] = a02 - a20;
      end else begin
         sq_in[0].sel = rmq_pkg::SEL_X;
         rad = m00 - m11 - m22 + one;
         d[0] = a10 + a01;
         d[1] = a20 + a02;
         d[2] = a21 - a12;
      end
      sq_in[0].valid = req_port.valid;
      sq_in[0].fault = (rad <= 0);
      for (int i = 0; i < 3; i++) begin
         sq_in[0].neg[i] = d[i][FW-1];
         sq_in[0].mag[i] = d[i][FW-1] ? FW'(-d[i]) : FW'(d[i]);
      end
      sq_in[0].n = NN'(rad[RAD_W-2:0]) << FRAC_BITS;
   end

   // square root, one result bit per stage
   for (genvar k = 0; k < SQ_W; k++) begin : g_sqrt
      always_comb begin
         logic [SQ_W+1:0] r, t;
         r = {sq_ff[k].rem[SQ_W-1:0], sq_ff[k].n[NN-1-2*k -: 2]};
         t = {sq_ff[k].root, 2'b01};
         sq_in[k+1] = sq_ff[k];
         if (r >= t) begin
            sq_in[k+1].rem = r - t;
            sq_in[k+1].root = {sq_ff[k].root[SQ_W-2:0], 1'b1};
         end else begin
            sq_in[k+1].rem = r;
            sq_in[k+1].root = {sq_ff[k].root[SQ_W-2:0], 1'b0};
         end
      end
   end

   for (genvar k = 0; k <= SQ_W; k++) begin : g_sq_reg
      always_ff @(posedge clock) begin
         if (reset) sq_ff[k] <= '0;
         else if (en) sq_ff[k] <= sq_in[k];
      end
   end

   // overflow check and main component
   always_comb begin
      logic [SQ_W-1:0] s;
      logic [CW-1:0] dvd;
      s = sq_ff[SQ_W].root;
      dv_in[0] = '0;
      dv_in[0].valid = sq_ff[SQ_W].valid;
      dv_in[0].fault = sq_ff[SQ_W].fault;
      dv_in[0].sel = sq_ff[SQ_W].sel;
      dv_in[0].neg = sq_ff[SQ_W].neg;
      dv_in[0].ds = CW'({s, 1'b0});
      if ((s >> 1) > SQ_W'(rmq_pkg::SAT_MAX))
         dv_in[0].main = rmq_pkg::SAT_MAX;
      else
         dv_in[0].main = DW'(s >> 1);
      for (int i = 0; i < 3; i++) begin
         dvd = CW'(sq_ff[SQ_W].mag[i]) << FRAC_BITS;
         dv_in[0].ovf[i] = (dvd >= (dv_in[0].ds << QB));
         dv_in[0].rem[i] = dvd;
      end
   end

   // restoring dividers, one quotient bit per stage
   for (genvar j = 0; j < QB; j++) begin : g_div
      always_comb begin
         logic [CW-1:0] t;
         t = dv_ff[j].ds << (QB - 1 - j);
         dv_in[j+1] = dv_ff[j];
         for (int i = 0; i < 3; i++) begin
            if (dv_ff[j].rem[i] >= t) begin
               dv_in[j+1].rem[i] = dv_ff[j].rem[i] - t;
               dv_in[j+1].q[i][QB-1-j] = 1'b1;
            end
         end
      end
   end

   for (genvar j = 0; j <= QB; j++) begin : g_dv_reg
      always_ff @(posedge clock) begin
         if (reset) dv_ff[j] <= '0;
         else if (en) dv_ff[j] <= dv_in[j];
      end
   end

   // sign, saturation and placement of the components
   always_comb begin
      logic signed [DW-1:0] v [0:2];
      dv_type f;
      f = dv_ff[QB];
      for (int i = 0; i < 3; i++) begin
         if (f.ovf[i])
            v[i] = f.neg[i] ? rmq_pkg::SAT_MIN : rmq_pkg::SAT_MAX;
         else if (f.neg[i])
            v[i] = -DW'({1'b0, f.q[i]});
         else
            v[i] = DW'({1'b0, f.q[i]});
      end
      out_in.valid = f.valid;
      out_in.fault = f.fault;
      out_in.quat = '0;
      case (f.sel)
         rmq_pkg::SEL_W: begin
            out_in.quat[0] = f.main;
            out_in.quat[1] = v[0];
            out_in.quat[2] = v[1];
            out_in.quat[3] = v[2];
         end
         rmq_pkg::SEL_Z: begin
            out_in.quat[3] = f.main;
            out_in.quat[1] = v[0];
            out_in.quat[2] = v[1];
            out_in.quat[0] = v[2];
         end
         rmq_pkg::SEL_Y: begin
            out_in.quat[2] = f.main;
            out_in.quat[1] = v[0];
            out_in.quat[3] = v[1];
            out_in.quat[0] = v[2];
         end
         default: begin
            out_in.quat[1] = f.main;
            out_in.quat[2] = v[0];
            out_in.quat[3] = v[1];
            out_in.quat[0] = v[2];
         end
      endcase
      if (f.fault) out_in.quat = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) out_ff <= '0;
      else if (en) out_ff <= out_in;
   end

   assign rsp_port.valid = out_ff.valid;
   assign rsp_port.root_fault = out_ff.fault;
   assign rsp_port.quat_w = out_ff.quat[0];
   assign rsp_port.quat_x = out_ff.quat[1];
   assign rsp_port.quat_y = out_ff.quat[2];
   assign rsp_port.quat_z = out_ff.quat[3];

endmodule

### tb/rmq_checker.sv
// channel monitor and quaternion predictor for the rotation matrix to quaternion block
`timescale 1ns / 1ps
module rmq_checker #(
   parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
   input logic clock,
   input logic reset,
   rmq_req_if req,
   rmq_rsp_if rsp,
   output int fail_count,
   output int pending,
   output int beats_checked,
   output int faults_seen
);

   typedef struct packed {
      logic signed [rmq_pkg::DATA_W-1:0] w;
      logic signed [rmq_pkg::DATA_W-1:0] x;
      logic signed [rmq_pkg::DATA_W-1:0] y;
      logic signed [rmq_pkg::DATA_W-1:0] z;
      logic fault;
   } quat_beat_type;

   quat_beat_type quat_fifo[$];

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic longint clamp16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // off-diagonal term times 0.5/s, truncated toward zero
   function automatic longint half_inv_scale(longint d, longint unsigned s);
      longint unsigned mag;
      longint unsigned q;
      mag = (d < 0) ? longint'(-d) : longint'(d);
      q = (mag << FRAC_BITS) / (s * 2);
      if (q > 40000) q = 40000;
      return clamp16((d < 0) ? -longint'(q) : longint'(q));
   endfunction

   function automatic quat_beat_type predict_quat(longint e[9]);
      quat_beat_type o;
      longint one, tr, rad;
      longint d[3];
      logic [1:0] main_sel;
      logic [1:0] oth[3];
      longint q[4];
      longint unsigned s;
      one = longint'(1) << FRAC_BITS;
      tr = e[0] + e[4] + e[8];
      q = '{0, 0, 0, 0};
      if (tr > 0) begin
         main_sel = rmq_pkg::SEL_W; rad = tr + one;
         oth = '{rmq_pkg::SEL_X, rmq_pkg::SEL_Y, rmq_pkg::SEL_Z};
         d = '{e[7] - e[5], e[2] - e[6], e[3] - e[1]};
      end else if ((e[4] > e[0] && e[8] > e[4]) || (!(e[4] > e[0]) && e[8] > e[0])) begin
         main_sel = rmq_pkg::SEL_Z; rad = e[8] - e[0] - e[4] + one;
         oth = '{rmq_pkg::SEL_X, rmq_pkg::SEL_Y, rmq_pkg::SEL_W};
         d = '{e[2] + e[6], e[5] + e[7], e[3] - e[1]};
      end else if (e[4] > e[0]) begin
         main_sel = rmq_pkg::SEL_Y; rad = e[4] - e[8] - e[0] + one;
         oth = '{rmq_pkg::SEL_X, rmq_pkg::SEL_Z, rmq_pkg::SEL_W};
         d = '{e[1] + e[3], e[7] + e[5], e[2] - e[6]};
      end else begin
         main_sel = rmq_pkg::SEL_X; rad = e[0] - e[4] - e[8] + one;
         oth = '{rmq_pkg::SEL_Y, rmq_pkg::SEL_Z, rmq_pkg::SEL_W};
         d = '{e[3] + e[1], e[6] + e[2], e[7] - e[5]};
      end
      o.fault = (rad <= 0);
      if (!o.fault) begin
         s = int_sqrt(longint'(rad) << FRAC_BITS);
         q[main_sel] = clamp16(longint'(s >> 1));
         for (int k = 0; k < 3; k++) q[oth[k]] = half_inv_scale(d[k], s);
      end
      o.w = q[rmq_pkg::SEL_W][rmq_pkg::DATA_W-1:0];
      o.x = q[rmq_pkg::SEL_X][rmq_pkg::DATA_W-1:0];
      o.y = q[rmq_pkg::SEL_Y][rmq_pkg::DATA_W-1:0];
      o.z = q[rmq_pkg::SEL_Z][rmq_pkg::DATA_W-1:0];
      return o;
   endfunction

   task automatic check_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
         $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   initial begin
      fail_count = 0;
      beats_checked = 0;
      faults_seen = 0;
   end

   assign pending = quat_fifo.size();

   always @(posedge clock) begin
      quat_beat_type exp_q;
      longint e[9];
      if (!reset) begin
         if (rsp.valid && rsp.ready) begin
            if (quat_fifo.size() == 0) begin
               $error("quaternion beat with nothing expected");
               fail_count++;
            end else begin
               exp_q = quat_fifo.pop_front();
               check_field("quat_w", exp_q.w, rsp.quat_w);
               check_field("quat_x", exp_q.x, rsp.quat_x);
               check_field("quat_y", exp_q.y, rsp.quat_y);
               check_field("quat_z", exp_q.z, rsp.quat_z);
               check_field("root_fault", exp_q.fault, rsp.root_fault);
               beats_checked++;
               if (exp_q.fault) faults_seen++;
            end
         end
         if (req.valid && req.ready) begin
            e = '{req.r00, req.r01, req.r02, req.r10, req.r11, req.r12,
                  req.r20, req.r21, req.r22};
            quat_fifo.push_back(predict_quat(e));
         end
      end
   end

endmodule

### tb/rotation_matrix_to_quaternion_tb.sv
// stimulus, flow control and verdict for the rotation matrix to quaternion block
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion_tb;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_BEATS = 470;
   localparam int DW = rmq_pkg::DATA_W;

   logic clock;
   logic reset;
   int fail_count, pending, beats_checked, faults_seen;
   int idle_pct, stall_pct, hold_cycles, cycles;
   int unsigned sent;
   logic signed [DW-1:0] mat[9];

   rmq_req_if req_bus ();
   rmq_rsp_if rsp_bus ();

   rotation_matrix_to_quaternion DUT (
      .clock(clock), .reset(reset), .req_port(req_bus), .rsp_port(rsp_bus)
   );

   rmq_checker u_checker (
      .clock(clock), .reset(reset), .req(req_bus), .rsp(rsp_bus),
      .fail_count(fail_count), .pending(pending),
      .beats_checked(beats_checked), .faults_seen(faults_seen)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("FAIL rotation_matrix_to_quaternion");
            $finish;
         end
      end
   end

   // receiver: random stalls plus long hold-offs on request
   initial begin
      rsp_bus.ready = 0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_bus.ready = 0;
         end else begin
            rsp_bus.ready = ($urandom_range(99) >= stall_pct);
         end
      end
   end

   task automatic send_matrix();
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid = 0;
         @(negedge clock);
      end
      {req_bus.r00, req_bus.r01, req_bus.r02} = {mat[0], mat[1], mat[2]};
      {req_bus.r10, req_bus.r11, req_bus.r12} = {mat[3], mat[4], mat[5]};
      {req_bus.r20, req_bus.r21, req_bus.r22} = {mat[6], mat[7], mat[8]};
      req_bus.valid = 1;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      sent++;
   endtask

   function automatic logic signed [DW-1:0] pick_elem();
      case ($urandom_range(4))
         0: return 16'($urandom);
         1: return $signed(16'($urandom_range(32767)));
         2: return 16'($urandom_range(16384)) - 16'sd8192;
         3: return $urandom_range(1) ? rmq_pkg::SAT_MAX : rmq_pkg::SAT_MIN;
         default: return 16'($urandom_range(32)) - 16'sd16;
      endcase
   endfunction

   task automatic random_matrix();
      for (int i = 0; i < 9; i++) mat[i] = pick_elem();
      // diagonal ties exercise the strict comparisons
      case ($urandom_range(5))
         0: mat[4] = mat[0];
         1: mat[8] = mat[4];
         2: mat[8] = mat[0];
         3: begin mat[4] = mat[0]; mat[8] = mat[0]; end
         default: ;
      endcase
   endtask

   task automatic directed_matrix(input int a0, a1, a2, a3, a4, a5, a6, a7, a8);
      mat = '{DW'(a0), DW'(a1), DW'(a2), DW'(a3), DW'(a4), DW'(a5), DW'(a6), DW'(a7),
              DW'(a8)};
      send_matrix();
   endtask

   initial begin
      req_bus.valid = 0;
      {req_bus.r00, req_bus.r01, req_bus.r02} = '0;
      {req_bus.r10, req_bus.r11, req_bus.r12} = '0;
      {req_bus.r20, req_bus.r21, req_bus.r22} = '0;
      idle_pct = 0;
      stall_pct = 0;
      hold_cycles = 0;
      sent = 0;
      reset = 1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // identity and the three half-turns pick each main component; a quarter-turn about z follows
      directed_matrix(16384, 0, 0, 0, 16384, 0, 0, 0, 16384);
      directed_matrix(16384, 0, 0, 0, -16384, 0, 0, 0, -16384);
      directed_matrix(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384);
      directed_matrix(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384);
      directed_matrix(0, -16384, 0, 16384, 0, 0, 0, 0, 16384);
      // zero trace with equal diagonal, then negative traces with ties on the diagonal comparisons
      directed_matrix(0, 32767, -32768, 32767, 0, 32767, -32768, 32767, 0);
      directed_matrix(0, -32768, -32768, -32768, 0, -32768, -32768, -32768, 0);
      directed_matrix(-100, 5, 6, 7, -100, 8, 9, 10, 50);
      directed_matrix(-100, 5, 6, 7, -50, 8, 9, 10, -50);
      directed_matrix(-100, 5, 6, 7, -50, 8, 9, 10, -20);
      directed_matrix(-10, 5, 6, 7, -50, 8, 9, 10, -10);
      // field extremes
      directed_matrix(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
      directed_matrix(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                      -32768);
      directed_matrix(-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768);
      directed_matrix(1, -32768, 32767, 32767, 0, -32768, -32768, 32767, 0);
      directed_matrix(-1, 0, 0, 0, 0, 0, 0, 0, 0);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0; stall_pct = 0; end
            1: begin idle_pct = 52; stall_pct = 0; end
            2: begin idle_pct = 0; stall_pct = 52; end
            default: begin idle_pct = 32; stall_pct = 32; end
         endcase
         for (int n = 0; n < PHASE_BEATS; n++) begin
            if (phase == 0 && n == 100) hold_cycles = 300;
            if (phase == 3 && n % 120 == 0) begin
               idle_pct = 0;
               stall_pct = 0;
            end else if (phase == 3 && n % 120 == 30) begin
               idle_pct = 32;
               stall_pct = 32;
            end
            random_matrix();
            send_matrix();
         end
      end
      req_bus.valid = 0;

      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("covered %0d matrix beats over four flow-control phases, %0d results checked",
               sent, beats_checked);
      $display("root faults seen: %0d, including a long output hold-off", faults_seen);
      if (fail_count == 0) begin
         $display("PASS rotation_matrix_to_quaternion");
      end else begin
         $display("FAIL rotation_matrix_to_quaternion");
      end
      $finish;
   end

endmodule
